### src/mono_page_framebuffer_plotter_top_defines.svh
// Assertion macros for the plotter's top-level RTL file.
`ifndef MONO_PAGE_FRAMEBUFFER_PLOTTER_TOP_DEFINES_SVH
`define MONO_PAGE_FRAMEBUFFER_PLOTTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPFP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPFP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mpfp_pkg.sv
package mpfp_pkg;

    typedef enum logic [1:0] {
        OP_FILL  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_IMAGE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [7:0] BIT_ONE = 8'h01;

    localparam logic CFG_COLUMN_OFFSET = 1'b0;
    localparam logic CFG_START_PAGE    = 1'b1;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_DATA_W  = 7;

    typedef struct packed {
        logic [7:0] column;
        logic [4:0] page;
        logic [7:0] byte_value;
        logic       in_range;
    } result_t;

endpackage

### src/mpfp_ram.sv
module mpfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

### src/mono_page_framebuffer_plotter_top.sv
// Page-organised 1-bit-per-pixel framebuffer of FB_WIDTH columns by FB_PAGES pages, held in a
// single-port-write, registered-read RAM that one small sequencer drives. A fill writes the
// whole store, one byte a cycle; after reset the same sweep clears the store, and s_tready
// stays low during it. A pixel write steps through accept, RAM read, and modify and write,
// then hands on the display write when one is asked for; a byte read steps through accept,
// RAM read, capture and result, or goes from accept straight to the result when the address
// lies outside the framebuffer; a pixel outside the framebuffer ends at accept. An image byte
// scans its pixels in turn, adding a RAM read and a modify and write for each drawn pixel.
// The RAM's registered read sets the read step in the read-modify-write. A result waits in
// an output register, so a later item may start while it is pending; the result step of the
// next item holds, and lengthens that item, until the pending beat has been taken.
`include "mono_page_framebuffer_plotter_top_defines.svh"

module mono_page_framebuffer_plotter_top
    import mpfp_pkg::*;
#(
    parameter int FB_WIDTH = 128,
    parameter int FB_PAGES = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // x_pos[7:0], y_pos[15:8], color[16], data[24:17], wrap[25], update_display[26], zeros
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // column[7:0], page[12:8], byte_value[20:13], in_range[21], zeros
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int DEPTH  = FB_WIDTH * FB_PAGES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = ADDR_W + 9;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [7:0]          x_reg, x_next;
    logic [7:0]          y_reg, y_next;
    logic                color_reg, color_next;
    logic [7:0]          data_reg, data_next;
    logic                wrap_reg, wrap_next;
    logic                upd_reg, upd_next;
    logic [8:0]          col_reg, col_next;
    logic [2:0]          bit_cnt_reg, bit_cnt_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [7:0]          res_byte_reg, res_byte_next;
    logic                res_in_range_reg, res_in_range_next;
    logic                m_valid_reg, m_valid_next;
    result_t             out_reg, out_next;
    logic [6:0]          column_offset_reg;
    logic [3:0]          start_page_reg;

    logic [8:0]          col_src;
    logic [7:0]          y_src;
    logic                pix_in;
    logic [SUM_W-1:0]    addr_full;
    logic [ADDR_W-1:0]   pix_addr;
    logic [8:0]          col_step;
    logic [7:0]          mask;
    logic [7:0]          new_byte;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [7:0]          ram_wdata;
    logic [7:0]          ram_rdata;
    logic                s_accept;

    mpfp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_reg.in_range, out_reg.byte_value, out_reg.page,
                       out_reg.column};

    assign col_src   = (state_reg == ST_IDLE) ? {1'b0, s_tdata[7:0]} : col_reg;
    assign y_src     = (state_reg == ST_IDLE) ? s_tdata[15:8] : y_reg;
    assign pix_in    = (col_src < 9'(FB_WIDTH)) && (y_src[7:3] < 5'(FB_PAGES));
    assign addr_full = SUM_W'(y_src[7:3]) * SUM_W'(FB_WIDTH) + SUM_W'(col_src);
    assign pix_addr  = addr_full[ADDR_W-1:0];
    assign mask      = BIT_ONE << y_reg[2:0];

    always_comb begin
        if (wrap_reg) begin
            col_step = (col_reg < 9'(FB_WIDTH - 1)) ? col_reg + 9'd1 : 9'd0;
        end else begin
            col_step = col_reg + 9'd1;
        end
    end

    always_comb begin
        if (op_reg == OP_PIXEL && !color_reg) begin
            new_byte = ram_rdata & ~mask;
        end else begin
            new_byte = ram_rdata | mask;
        end
    end

    always_comb begin
        state_next        = state_reg;
        op_next           = op_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        color_next        = color_reg;
        data_next         = data_reg;
        wrap_next         = wrap_reg;
        upd_next          = upd_reg;
        col_next          = col_reg;
        bit_cnt_next      = bit_cnt_reg;
        addr_next         = addr_reg;
        res_byte_next     = res_byte_reg;
        res_in_range_next = res_in_range_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        out_next          = out_reg;
        ram_we            = 1'b0;
        ram_waddr         = addr_reg;
        ram_wdata         = new_byte;

        unique case (state_reg)
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = data_reg;
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next      = op_t'(s_tuser[1:0]);
                    x_next       = s_tdata[7:0];
                    y_next       = s_tdata[15:8];
                    color_next   = s_tdata[16];
                    data_next    = s_tdata[24:17];
                    wrap_next    = s_tdata[25];
                    upd_next     = s_tdata[26];
                    col_next     = {1'b0, s_tdata[7:0]};
                    bit_cnt_next = 3'd0;
                    addr_next    = pix_addr;
                    unique case (op_t'(s_tuser[1:0]))
                        OP_FILL: begin
                            addr_next  = '0;
                            state_next = ST_FILL;
                        end
                        OP_PIXEL: begin
                            state_next = pix_in ? ST_RD : ST_IDLE;
                        end
                        OP_IMAGE: begin
                            state_next = ST_SCAN;
                        end
                        OP_READ: begin
                            if (pix_in) begin
                                state_next = ST_RD;
                            end else begin
                                res_byte_next     = 8'd0;
                                res_in_range_next = 1'b0;
                                state_next        = ST_EMIT;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD: begin
                state_next = ST_WR;
            end
            ST_WR: begin
                unique case (op_reg)
                    OP_READ: begin
                        res_byte_next     = ram_rdata;
                        res_in_range_next = 1'b1;
                        state_next        = ST_EMIT;
                    end
                    OP_PIXEL: begin
                        ram_we = 1'b1;
                        if (upd_reg) begin
                            res_byte_next     = new_byte;
                            res_in_range_next = 1'b1;
                            state_next        = ST_EMIT;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    OP_IMAGE: begin
                        ram_we       = 1'b1;
                        col_next     = col_step;
                        data_next    = {data_reg[6:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        state_next   = (bit_cnt_reg == 3'd7) ? ST_IDLE : ST_SCAN;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (data_reg[7] && pix_in) begin
                    addr_next  = pix_addr;
                    state_next = ST_RD;
                end else begin
                    col_next     = col_step;
                    data_next    = {data_reg[6:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    state_next   = (bit_cnt_reg == 3'd7) ? ST_IDLE : ST_SCAN;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next        = 1'b1;
                    out_next.byte_value = res_byte_reg;
                    out_next.in_range   = res_in_range_reg;
                    if (res_in_range_reg) begin
                        out_next.column = x_reg + {1'b0, column_offset_reg};
                        out_next.page   = y_reg[7:3] + {1'b0, start_page_reg};
                    end else begin
                        out_next.column = 8'd0;
                        out_next.page   = 5'd0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_FILL;
            addr_reg          <= '0;
            data_reg          <= 8'd0;
            m_valid_reg       <= 1'b0;
            column_offset_reg <= 7'd0;
            start_page_reg    <= 4'd0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            data_reg    <= data_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_COLUMN_OFFSET: column_offset_reg <= cfg_wdata[6:0];
                    CFG_START_PAGE:    start_page_reg    <= cfg_wdata[3:0];
                    default: begin
                        column_offset_reg <= column_offset_reg;
                    end
                endcase
            end
        end
        op_reg           <= op_next;
        x_reg            <= x_next;
        y_reg            <= y_next;
        color_reg        <= color_next;
        wrap_reg         <= wrap_next;
        upd_reg          <= upd_next;
        col_reg          <= col_next;
        bit_cnt_reg      <= bit_cnt_next;
        res_byte_reg     <= res_byte_next;
        res_in_range_reg <= res_in_range_next;
        out_reg          <= out_next;
    end

    `MPFP_ASSERT_IMP(a_idle_no_write, aclk, aresetn, state_reg == ST_IDLE, !ram_we,
                     "store written while idle")
    `MPFP_ASSERT_IMP(a_write_in_range, aclk, aresetn, ram_we,
                     ram_waddr <= ADDR_W'(DEPTH - 1), "store write address out of range")
    `MPFP_ASSERT_IMP(a_miss_zero, aclk, aresetn, m_valid_reg && !out_reg.in_range,
                     out_reg.column == 8'd0 && out_reg.page == 5'd0 && out_reg.byte_value == 8'd0,
                     "out-of-range result not zero")
    `MPFP_ASSERT_NXT(a_fill_starts, aclk, aresetn, s_accept && s_tuser[1:0] == OP_FILL,
                     state_reg == ST_FILL, "fill did not start a sweep")

endmodule
